[hw/rtl/swk_pkg.sv]
// Package: shared types, constants and the arctangent table for the swerve kinematics block.
`default_nettype none
package swk_pkg;
   localparam int CORDIC_STEPS = 16;
   localparam int WHEEL_COUNT  = 4;
   localparam int XW = 37;
   localparam int ZW = 33;
   localparam logic [31:0] PI_Q29 = 32'd1686629713;
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

   localparam logic [2:0] REG_HALF_WHEEL_BASE = 3'd0;
   localparam logic [2:0] REG_HALF_TRACK      = 3'd1;
   localparam logic [2:0] REG_INV_RADIUS      = 3'd2;
   localparam logic [2:0] REG_MAX_SPEED       = 3'd3;
   localparam logic [2:0] REG_MAX_ANGLE       = 3'd4;
   localparam logic [2:0] REG_TIMEOUT         = 3'd5;

   typedef struct packed {
      logic [14:0] max_angle;
      logic [15:0] inv_radius;
      logic [15:0] max_speed;
   } cordic_cfg_type;

   typedef struct packed {
      logic signed [15:0] angle;
      logic [15:0]        speed;
   } wheel_res_type;

   function automatic logic [29:0] atan_q29(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:  r = 30'd421657428;
         5'd1:  r = 30'd248918915;
         5'd2:  r = 30'd131521918;
         5'd3:  r = 30'd66762579;
         5'd4:  r = 30'd33510843;
         5'd5:  r = 30'd16771758;
         5'd6:  r = 30'd8387925;
         5'd7:  r = 30'd4194219;
         5'd8:  r = 30'd2097141;
         5'd9:  r = 30'd1048575;
         5'd10: r = 30'd524288;
         5'd11: r = 30'd262144;
         5'd12: r = 30'd131072;
         5'd13: r = 30'd65536;
         5'd14: r = 30'd32768;
         5'd15: r = 30'd16384;
         5'd16: r = 30'd8192;
         5'd17: r = 30'd4096;
         5'd18: r = 30'd2048;
         5'd19: r = 30'd1024;
         5'd20: r = 30'd512;
         5'd21: r = 30'd256;
         5'd22: r = 30'd128;
         5'd23: r = 30'd64;
         default: r = 30'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

[hw/rtl/swk_if.sv]
// Interfaces: request and response channels of the swerve kinematics block.
`default_nettype none
interface swk_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] yaw_rate;
   modport source (output valid, command, vel_x, vel_y, yaw_rate, input ready);
   modport sink (input valid, command, vel_x, vel_y, yaw_rate, output ready);
endinterface

interface swk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] angle_left_front;
   logic signed [15:0] angle_right_front;
   logic signed [15:0] angle_left_back;
   logic signed [15:0] angle_right_back;
   logic [15:0]        speed_left_front;
   logic [15:0]        speed_right_front;
   logic [15:0]        speed_left_back;
   logic [15:0]        speed_right_back;
   logic               timed_out;
   modport source (output valid, angle_left_front, angle_right_front, angle_left_back,
      angle_right_back, speed_left_front, speed_right_front, speed_left_back,
      speed_right_back, timed_out, input ready);
   modport sink (input valid, angle_left_front, angle_right_front, angle_left_back,
      angle_right_back, speed_left_front, speed_right_front, speed_left_back,
      speed_right_back, timed_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/swk_cordic.sv]
// Shared CORDIC unit: one vectoring step per cycle, then speed scaling and clamps.
`default_nettype none
module swk_cordic #(
   parameter int STEPS = swk_pkg::CORDIC_STEPS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [swk_pkg::XW-1:0] x_start,
   input  wire logic signed [swk_pkg::XW-1:0] y_start,
   input  wire swk_pkg::cordic_cfg_type       cfg,
   output logic                               done,
   output swk_pkg::wheel_res_type             result
);
   localparam int XW = swk_pkg::XW;
   localparam int ZW = swk_pkg::ZW;
   localparam int CW = $clog2(STEPS + 1);

   typedef enum logic [2:0] {C_IDLE, C_ITER, C_MLO, C_MHI, C_MR} cstate_type;

   cstate_type             state_ff;
   logic signed [XW-1:0]   x_ff, y_ff;
   logic signed [ZW-1:0]   z_ff;
   logic [CW-1:0]          cnt_ff;
   logic [65:0]            acc_ff;
   logic                   done_ff;
   swk_pkg::wheel_res_type res_ff;

   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] at;
   logic [46:0]          plo;
   logic [48:0]          phi;
   logic [35:0]          mag;
   logic [51:0]          prod;
   logic [51:0]          rnd;
   logic [23:0]          spd;
   logic signed [ZW-1:0] zr;
   logic signed [16:0]   ang, lim;

   assign xs   = x_ff >>> cnt_ff;
   assign ys   = y_ff >>> cnt_ff;
   assign at   = ZW'(swk_pkg::atan_q29(5'(cnt_ff)));
   assign plo  = 47'(x_ff[16:0]) * 47'(swk_pkg::INV_GAIN_Q30);
   assign phi  = 49'(x_ff[35:17]) * 49'(swk_pkg::INV_GAIN_Q30);
   assign mag  = acc_ff[65:30];
   assign prod = 52'(mag) * 52'(cfg.inv_radius);
   assign rnd  = prod + 52'd134217728;
   assign spd  = rnd[51:28];
   assign zr   = z_ff + ZW'(32768);
   assign ang  = zr[32:16];
   assign lim  = {2'b00, cfg.max_angle};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= C_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            C_IDLE: begin
               if (start) begin
                  cnt_ff <= '0;
                  if (x_start == '0 && y_start == '0) begin
                     res_ff  <= '0;
                     done_ff <= 1'b1;
                  end else begin
                     state_ff <= C_ITER;
                     if (x_start < 0) begin
                        x_ff <= -x_start;
                        y_ff <= -y_start;
                        z_ff <= (y_start >= 0) ? ZW'(swk_pkg::PI_Q29)
                                               : -ZW'(swk_pkg::PI_Q29);
                     end else begin
                        x_ff <= x_start;
                        y_ff <= y_start;
                        z_ff <= '0;
                     end
                  end
               end
            end
            C_ITER: begin
               if (y_ff >= 0) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + at;
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - at;
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(STEPS - 1)) begin
                  state_ff <= C_MLO;
               end
            end
            C_MLO: begin
               acc_ff   <= 66'(plo);
               state_ff <= C_MHI;
            end
            C_MHI: begin
               acc_ff   <= acc_ff + {phi, 17'b0};
               state_ff <= C_MR;
            end
            C_MR: begin
               res_ff.speed <= (spd > 24'(cfg.max_speed)) ? cfg.max_speed : spd[15:0];
               if (ang > lim) begin
                  res_ff.angle <= lim[15:0];
               end else if (ang < -lim) begin
                  res_ff.angle <= 16'(-lim);
               end else begin
                  res_ff.angle <= ang[15:0];
               end
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == C_IDLE) else $error("start while busy");
   a_x_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == C_MLO |-> !x_ff[XW-1]) else $error("negative magnitude");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held");
endmodule
`default_nettype wire

[hw/rtl/swerve_wheel_kinematics_top.sv]
// Top level: command store, tick timeout, and the wheel sequencer around the CORDIC unit.
// A velocity command is taken while idle and gives no response.
// A tick runs the single shared CORDIC unit for each wheel in turn, one step per cycle.
// One item at a time; the next request is taken once the response has been delivered.
// Synchronous reset loads the register defaults and clears the held command and counter.
`default_nettype none
module swerve_wheel_kinematics_top #(
   parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   swk_req_if.sink          req_chan,
   swk_rsp_if.source        rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wr_data
);
   localparam int XW = swk_pkg::XW;

   typedef enum logic [2:0] {T_IDLE, T_PREP, T_START, T_WAIT, T_OUT} tstate_type;

   tstate_type         state_ff;
   logic [15:0]        hwb_ff, htr_ff, invr_ff, maxs_ff, tmo_ff, cnt_ff;
   logic [14:0]        maxa_ff;
   logic signed [15:0] vx_ff, vy_ff, wz_ff;
   logic signed [32:0] wd_ff, wb_ff;
   logic [1:0]         wheel_ff;
   logic               tout_ff;
   swk_pkg::wheel_res_type res_ff [swk_pkg::WHEEL_COUNT];

   logic [15:0]          cnt_in;
   logic signed [XW-1:0] vx_s, vy_s, x_w, y_w;
   logic                 cstart, cdone;
   swk_pkg::cordic_cfg_type ccfg;
   swk_pkg::wheel_res_type  cres;

   assign cnt_in = (cnt_ff == 16'hFFFF) ? cnt_ff : cnt_ff + 16'd1;
   assign vx_s   = XW'(vx_ff) <<< 16;
   assign vy_s   = XW'(vy_ff) <<< 16;
   assign x_w    = wheel_ff[0] ? vx_s + XW'(wd_ff) : vx_s - XW'(wd_ff);
   assign y_w    = wheel_ff[1] ? vy_s - XW'(wb_ff) : vy_s + XW'(wb_ff);
   assign cstart = state_ff == T_START;
   assign ccfg   = '{max_angle: maxa_ff, inv_radius: invr_ff, max_speed: maxs_ff};

   swk_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cstart), .x_start(x_w), .y_start(y_w),
      .cfg(ccfg), .done(cdone), .result(cres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         hwb_ff   <= 16'd11862;
         htr_ff   <= 16'd11862;
         invr_ff  <= 16'd5120;
         maxs_ff  <= 16'd2560;
         maxa_ff  <= 15'd12868;
         tmo_ff   <= 16'd500;
         vx_ff    <= '0;
         vy_ff    <= '0;
         wz_ff    <= '0;
         cnt_ff   <= '0;
         wheel_ff <= '0;
         tout_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               swk_pkg::REG_HALF_WHEEL_BASE: hwb_ff  <= csr_wr_data;
               swk_pkg::REG_HALF_TRACK:      htr_ff  <= csr_wr_data;
               swk_pkg::REG_INV_RADIUS:      invr_ff <= csr_wr_data;
               swk_pkg::REG_MAX_SPEED:       maxs_ff <= csr_wr_data;
               swk_pkg::REG_MAX_ANGLE:       maxa_ff <= csr_wr_data[14:0];
               swk_pkg::REG_TIMEOUT:         tmo_ff  <= csr_wr_data;
               default: ;
            endcase
         end
         case (state_ff)
            T_IDLE: begin
               if (req_chan.valid) begin
                  if (!req_chan.command) begin
                     vx_ff  <= req_chan.vel_x;
                     vy_ff  <= req_chan.vel_y;
                     wz_ff  <= req_chan.yaw_rate;
                     cnt_ff <= '0;
                  end else begin
                     cnt_ff   <= cnt_in;
                     tout_ff  <= cnt_in > tmo_ff;
                     if (cnt_in > tmo_ff) begin
                        vx_ff <= '0;
                        vy_ff <= '0;
                        wz_ff <= '0;
                     end
                     wheel_ff <= '0;
                     state_ff <= T_PREP;
                  end
               end
            end
            T_PREP: begin
               wd_ff    <= wz_ff * $signed({1'b0, htr_ff});
               wb_ff    <= wz_ff * $signed({1'b0, hwb_ff});
               state_ff <= T_START;
            end
            T_START: state_ff <= T_WAIT;
            T_WAIT: begin
               if (cdone) begin
                  res_ff[wheel_ff] <= cres;
                  wheel_ff <= wheel_ff + 2'd1;
                  state_ff <= (wheel_ff == 2'd3) ? T_OUT : T_START;
               end
            end
            T_OUT: begin
               if (rsp_chan.ready) begin
                  state_ff <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign req_chan.ready             = state_ff == T_IDLE;
   assign rsp_chan.valid             = state_ff == T_OUT;
   assign rsp_chan.angle_left_front  = res_ff[0].angle;
   assign rsp_chan.angle_right_front = res_ff[1].angle;
   assign rsp_chan.angle_left_back   = res_ff[2].angle;
   assign rsp_chan.angle_right_back  = res_ff[3].angle;
   assign rsp_chan.speed_left_front  = res_ff[0].speed;
   assign rsp_chan.speed_right_front = res_ff[1].speed;
   assign rsp_chan.speed_left_back   = res_ff[2].speed;
   assign rsp_chan.speed_right_back  = res_ff[3].speed;
   assign rsp_chan.timed_out         = tout_ff;

   a_cmd_clears: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && !req_chan.command |=> cnt_ff == '0)
      else $error("counter not restarted");
   a_tout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.timed_out |-> vx_ff == '0 && wz_ff == '0)
      else $error("timeout left command");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      cstart |-> !req_chan.ready && !rsp_chan.valid) else $error("overlap");
endmodule
`default_nettype wire

[bench/swerve_wheel_kinematics_top_tb.sv]
// Testbench: swerve kinematics block against an in-bench CORDIC predictor, directed and random.
`timescale 1ns / 100ps
module swerve_wheel_kinematics_top_tb;

   typedef struct packed {
      logic signed [15:0] alf, arf, alb, arb;
      logic [15:0]        slf, srf, slb, srb;
      logic               tout;
   } wheel_set_type;

   typedef struct {
      logic               cmd;
      logic signed [15:0] vx, vy, wz;
      logic               chk;
      wheel_set_type      want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wr_data = '0;

   swk_req_if req_chan ();
   swk_rsp_if rsp_chan ();

   swerve_wheel_kinematics_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // predictor state
   logic [15:0] p_hwb, p_ht, p_irad, p_maxspd, p_tmo;
   logic [14:0] p_maxang;
   logic signed [15:0] h_vx, h_vy, h_wz;
   logic [15:0] h_ticks;

   wheel_set_type wheel_q[$];
   wheel_set_type fixed_q[$];
   bit            fixed_chk_q[$];
   int fails = 0;
   int unsigned cycles = 0;
   bit sender_hold = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic longint asr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void solve_wheel(input longint xi, input longint yi,
         output logic signed [15:0] ang, output logic [15:0] spd);
      longint x, y, z, xs, ys, a, lim;
      logic [127:0] m;
      x = xi; y = yi; z = 0;
      if (x == 0 && y == 0) begin
         ang = '0; spd = '0;
         return;
      end
      if (x < 0) begin
         z = (y >= 0) ? longint'(swk_pkg::PI_Q29) : -longint'(swk_pkg::PI_Q29);
         x = -x; y = -y;
      end
      for (int i = 0; i < swk_pkg::CORDIC_STEPS; i++) begin
         xs = asr_floor(x, i); ys = asr_floor(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + longint'(swk_pkg::atan_q29(i[4:0]));
         end else begin
            x = x - ys; y = y + xs; z = z - longint'(swk_pkg::atan_q29(i[4:0]));
         end
      end
      a = asr_floor(z + 32768, 16);
      lim = longint'(p_maxang);
      if (a > lim) a = lim;
      if (a < -lim) a = -lim;
      ang = a[15:0];
      m = (128'(x) * 128'(swk_pkg::INV_GAIN_Q30)) >> 30;
      m = (m * 128'(p_irad) + (128'd1 << 27)) >> 28;
      if (m > 128'(p_maxspd)) m = 128'(p_maxspd);
      spd = m[15:0];
   endfunction

   function automatic bit kinematics_step(input logic cmd, input logic signed [15:0] vx,
         input logic signed [15:0] vy, input logic signed [15:0] wz,
         output wheel_set_type r);
      longint bx, by, wd, wb, x, y;
      logic signed [15:0] ang [4];
      logic [15:0] spd [4];
      r = '0;
      if (!cmd) begin
         h_vx = vx; h_vy = vy; h_wz = wz; h_ticks = '0;
         return 0;
      end
      if (h_ticks != 16'hFFFF) h_ticks++;
      if (h_ticks > p_tmo) begin
         h_vx = '0; h_vy = '0; h_wz = '0; r.tout = 1'b1;
      end
      bx = longint'(h_vx) * 65536;
      by = longint'(h_vy) * 65536;
      wd = longint'(h_wz) * longint'(p_ht);
      wb = longint'(h_wz) * longint'(p_hwb);
      for (int w = 0; w < 4; w++) begin
         x = (w & 1) ? bx + wd : bx - wd;
         y = (w & 2) ? by - wb : by + wb;
         solve_wheel(x, y, ang[w], spd[w]);
      end
      r.alf = ang[0]; r.arf = ang[1]; r.alb = ang[2]; r.arb = ang[3];
      r.slf = spd[0]; r.srf = spd[1]; r.slb = spd[2]; r.srb = spd[3];
      return 1;
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         swk_pkg::REG_HALF_WHEEL_BASE: p_hwb = val;
         swk_pkg::REG_HALF_TRACK:      p_ht = val;
         swk_pkg::REG_INV_RADIUS:      p_irad = val;
         swk_pkg::REG_MAX_SPEED:       p_maxspd = val;
         swk_pkg::REG_MAX_ANGLE:       p_maxang = val[14:0];
         swk_pkg::REG_TIMEOUT:         p_tmo = val;
         default: ;
      endcase
   endtask

   task automatic drain_and_settle;
      while (wheel_q.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // burst/gap pacing for the sender
   int burst_left = 0;
   task automatic send_request(input logic cmd, input logic signed [15:0] vx,
         input logic signed [15:0] vy, input logic signed [15:0] wz,
         input bit chk, input wheel_set_type want);
      wheel_set_type r;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 40)) : 0;
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.vel_x <= vx; req_chan.vel_y <= vy; req_chan.yaw_rate <= wz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (kinematics_step(cmd, vx, vy, wz, r)) begin
         wheel_q.push_back(r);
         fixed_q.push_back(want);
         fixed_chk_q.push_back(chk);
      end
      @(negedge clock);
   endtask

   task automatic random_request(input int mode);
      logic signed [15:0] vx, vy, wz;
      int span;
      span = ($urandom_range(0, 3) == 0) ? 32767 : 8192;
      vx = 16'($urandom_range(0, 2 * span) - span);
      vy = 16'($urandom_range(0, 2 * span) - span);
      wz = 16'($urandom_range(0, 2 * span) - span);
      if (mode == 0) vx = 16'($urandom);
      if ($urandom_range(0, 9) == 0) vy = '0;
      send_request(($urandom_range(0, 3) != 0), vx, vy, wz, 1'b0, '0);
   endtask

   // response side
   always @(posedge clock) begin
      wheel_set_type got, exp_r, fix;
      bit fchk;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.angle_left_front, rsp_chan.angle_right_front,
                rsp_chan.angle_left_back, rsp_chan.angle_right_back,
                rsp_chan.speed_left_front, rsp_chan.speed_right_front,
                rsp_chan.speed_left_back, rsp_chan.speed_right_back, rsp_chan.timed_out};
         if (wheel_q.size() == 0) begin
            $display("%0t unexpected response %h", $realtime, got);
            fails++;
         end else begin
            exp_r = wheel_q.pop_front();
            fix = fixed_q.pop_front();
            fchk = fixed_chk_q.pop_front();
            if (fchk && fix != exp_r) begin
               $display("%0t table row disagrees: exp %h pred %h", $realtime, fix, exp_r);
               fails++;
            end
            if (got.alf !== exp_r.alf) begin
               $display("%0t angle_lf exp %0d got %0d", $realtime, exp_r.alf, got.alf); fails++;
            end
            if (got.arf !== exp_r.arf) begin
               $display("%0t angle_rf exp %0d got %0d", $realtime, exp_r.arf, got.arf); fails++;
            end
            if (got.alb !== exp_r.alb) begin
               $display("%0t angle_lb exp %0d got %0d", $realtime, exp_r.alb, got.alb); fails++;
            end
            if (got.arb !== exp_r.arb) begin
               $display("%0t angle_rb exp %0d got %0d", $realtime, exp_r.arb, got.arb); fails++;
            end
            if (got.slf !== exp_r.slf) begin
               $display("%0t speed_lf exp %0d got %0d", $realtime, exp_r.slf, got.slf); fails++;
            end
            if (got.srf !== exp_r.srf) begin
               $display("%0t speed_rf exp %0d got %0d", $realtime, exp_r.srf, got.srf); fails++;
            end
            if (got.slb !== exp_r.slb) begin
               $display("%0t speed_lb exp %0d got %0d", $realtime, exp_r.slb, got.slb); fails++;
            end
            if (got.srb !== exp_r.srb) begin
               $display("%0t speed_rb exp %0d got %0d", $realtime, exp_r.srb, got.srb); fails++;
            end
            if (got.tout !== exp_r.tout) begin
               $display("%0t timed_out exp %0b got %0b", $realtime, exp_r.tout, got.tout);
               fails++;
            end
         end
      end
   end

   // receiver stall pattern
   logic [6:0] stall_ctr = '0;
   always @(negedge clock) begin
      stall_ctr <= stall_ctr + 7'd1;
      if (stall_ctr < 32) rsp_chan.ready <= 1'b1;
      else if (stall_ctr < 96) rsp_chan.ready <= ($urandom_range(0, 2) != 0);
      else rsp_chan.ready <= (stall_ctr[2:0] == 0) && ($urandom_range(0, 3) != 0);
   end

   stim_row_type dir_rows[$];

   function automatic stim_row_type row(input int cmd, input int vx, input int vy,
         input int wz, input int chk, input wheel_set_type want);
      stim_row_type s;
      s.cmd = cmd[0]; s.vx = 16'(vx); s.vy = 16'(vy); s.wz = 16'(wz);
      s.chk = chk[0]; s.want = want;
      return s;
   endfunction

   initial begin
      stim_row_type s;
      wheel_set_type tout_only;
      req_chan.valid = 1'b0; req_chan.command = 1'b1;
      req_chan.vel_x = '0; req_chan.vel_y = '0; req_chan.yaw_rate = '0;
      rsp_chan.ready = 1'b1;
      p_hwb = 16'd11862; p_ht = 16'd11862; p_irad = 16'd5120; p_maxspd = 16'd2560;
      p_maxang = 15'd12868; p_tmo = 16'd500;
      h_vx = '0; h_vy = '0; h_wz = '0; h_ticks = '0;
      tout_only = '0;
      tout_only.tout = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: zero vector, nothing timed out
      dir_rows.push_back(row(1, 0, 0, 0, 1, '0));
      dir_rows.push_back(row(0, 4096, 0, 0, 0, '0));
      dir_rows.push_back(row(1, 0, 0, 0, 0, '0));
      dir_rows.push_back(row(0, 0, 4096, 0, 0, '0));
      dir_rows.push_back(row(1, 0, 0, 0, 0, '0));
      dir_rows.push_back(row(0, -4096, 0, 0, 0, '0));
      dir_rows.push_back(row(1, 0, 0, 0, 0, '0));
      dir_rows.push_back(row(0, -4096, -1, 0, 0, '0));
      dir_rows.push_back(row(1, 0, 0, 0, 0, '0));
      dir_rows.push_back(row(0, 32767, 32767, 32767, 0, '0));
      dir_rows.push_back(row(1, 0, 0, 0, 0, '0));
      dir_rows.push_back(row(0, -32768, -32768, -32768, 0, '0));
      dir_rows.push_back(row(1, 0, 0, 0, 0, '0));
      dir_rows.push_back(row(0, 0, 0, 4096, 0, '0));
      dir_rows.push_back(row(1, 0, 0, 0, 0, '0));
      dir_rows.push_back(row(0, 0, -32768, 0, 0, '0));
      dir_rows.push_back(row(1, 0, 0, 0, 0, '0));
      foreach (dir_rows[i]) begin
         s = dir_rows[i];
         send_request(s.cmd, s.vx, s.vy, s.wz, s.chk, s.want);
      end
      req_chan.valid <= 1'b0;
      drain_and_settle();

      // timeout of zero: first tick after a command times out, zero result
      csr_write(swk_pkg::REG_TIMEOUT, 16'd0);
      send_request(1'b0, 16'sd1000, 16'sd2000, 16'sd300, 1'b0, '0);
      send_request(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, tout_only);
      send_request(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, tout_only);
      req_chan.valid <= 1'b0;
      drain_and_settle();

      // extremes of every register
      csr_write(swk_pkg::REG_HALF_WHEEL_BASE, 16'hFFFF);
      csr_write(swk_pkg::REG_HALF_TRACK, 16'hFFFF);
      csr_write(swk_pkg::REG_INV_RADIUS, 16'hFFFF);
      csr_write(swk_pkg::REG_MAX_SPEED, 16'hFFFF);
      csr_write(swk_pkg::REG_MAX_ANGLE, 16'h7FFF);
      csr_write(swk_pkg::REG_TIMEOUT, 16'd3);
      csr_write(3'd7, 16'h1234);
      for (int k = 0; k < 150; k++) random_request(k % 3);
      req_chan.valid <= 1'b0;
      drain_and_settle();

      csr_write(swk_pkg::REG_HALF_WHEEL_BASE, 16'd0);
      csr_write(swk_pkg::REG_HALF_TRACK, 16'd0);
      csr_write(swk_pkg::REG_INV_RADIUS, 16'd0);
      csr_write(swk_pkg::REG_MAX_SPEED, 16'd0);
      csr_write(swk_pkg::REG_MAX_ANGLE, 16'd0);
      csr_write(swk_pkg::REG_TIMEOUT, 16'hFFFF);
      for (int k = 0; k < 100; k++) random_request(1);
      req_chan.valid <= 1'b0;
      drain_and_settle();

      for (int ph = 0; ph < 6; ph++) begin
         csr_write(swk_pkg::REG_HALF_WHEEL_BASE, 16'($urandom));
         csr_write(swk_pkg::REG_HALF_TRACK, 16'($urandom));
         csr_write(swk_pkg::REG_INV_RADIUS, 16'($urandom_range(256, 8192)));
         csr_write(swk_pkg::REG_MAX_SPEED, 16'($urandom));
         csr_write(swk_pkg::REG_MAX_ANGLE, 16'($urandom_range(0, 25736)));
         csr_write(swk_pkg::REG_TIMEOUT, 16'($urandom_range(0, 12)));
         for (int k = 0; k < 280; k++) random_request(k % 5);
         req_chan.valid <= 1'b0;
         drain_and_settle();
      end

      while (wheel_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
